// ===== rtl/wtht_pkg.sv =====
// Package for the window table hit test block: operation and status codes,
// slot record type, its width and the default slot count. No dependencies.
`timescale 1ns / 1ps
package wtht_pkg;

    localparam int SLOTS_DEFAULT = 16;

    typedef enum logic [2:0] {
        FN_CREATE  = 3'd0,
        FN_DESTROY = 3'd1,
        FN_BOUNDS  = 3'd2,
        FN_FOCUS   = 3'd3,
        FN_VISIBLE = 3'd4,
        FN_HIT     = 3'd5,
        FN_RSV6    = 3'd6,
        FN_RSV7    = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One slot as stored in the table memory.
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] left;
        logic [15:0] top;
        logic [14:0] width;
        logic [14:0] height;
        logic [31:0] depth;
        logic        visible;
        logic        focused;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== rtl/wtht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wtht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/window_table_hit_test.sv =====
// Top level of the window table hit test block. Uses wtht_pkg and wtht_ram.
// A request runs one scan of the slot table, then a write-back state; a found
// focus target needs two more scans instead. The scan reads one slot a cycle.
// Only one request at a time is taken; the next is accepted the cycle after
// the result is taken.
// Reset clears the slot valid bits (all slots free) and sets next id to one.
`timescale 1ns / 1ps
module window_table_hit_test #(
    parameter int SLOTS = wtht_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [31:0] s_target_id,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [14:0] s_size_w,
    input  logic [14:0] s_size_h,
    input  logic signed [31:0] s_depth_z,
    input  logic        s_visible_flag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_surface_id,
    output logic        m_hit,
    output logic [14:0] m_local_x,
    output logic [14:0] m_local_y
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FSCAN, S_WRITE, S_FWRITE, S_DONE
    } state_t;

    state_t state_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] focus_clr_reg;
    logic [31:0] next_id_reg;
    logic [CW-1:0] rd_cnt_reg;  // address issued
    logic [CW-1:0] ev_cnt_reg;  // slot whose data is on rd_data
    logic          ev_on_reg;

    // Captured request.
    wtht_pkg::func_t func_reg;
    logic [31:0] tid_reg;
    logic [15:0] px_reg, py_reg;
    logic [14:0] w_reg, h_reg;
    logic [31:0] z_reg;
    logic        vis_reg;

    // Scan results.
    logic          fnd_reg;
    logic [AW-1:0] fidx_reg;
    wtht_pkg::slot_t fslot_reg;
    logic [31:0]   maxz_reg;
    logic          free_reg;
    logic [AW-1:0] free_idx_reg;

    // Output register.
    logic [1:0]  o_status_reg;
    logic [31:0] o_id_reg;
    logic        o_hit_reg;
    logic [14:0] o_lx_reg, o_ly_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    wtht_pkg::slot_t wr_data, rd_slot;
    logic [wtht_pkg::SLOT_W-1:0] rd_raw;

    wtht_ram #(.WIDTH(wtht_pkg::SLOT_W), .DEPTH(SLOTS)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_raw)
    );

    logic [AW-1:0] ev_idx;
    logic          ev_used;
    assign ev_idx  = ev_cnt_reg[AW-1:0];
    assign rd_addr = rd_cnt_reg[AW-1:0];
    assign ev_used = valid_reg[ev_idx];
    assign rd_slot = wtht_pkg::slot_t'(rd_raw);

    // Hit test containment: widen to 17 bits so sums never overflow.
    logic signed [16:0] hx, hy, hl, ht, hr, hb;
    logic contains, deeper, id_match, zgt;
    assign hx = {px_reg[15], px_reg};
    assign hy = {py_reg[15], py_reg};
    assign hl = {rd_slot.left[15], rd_slot.left};
    assign ht = {rd_slot.top[15], rd_slot.top};
    assign hr = hl + $signed({2'b00, rd_slot.width});
    assign hb = ht + $signed({2'b00, rd_slot.height});
    assign contains = ev_used && rd_slot.visible && hx >= hl && hy >= ht
                      && hx < hr && hy < hb;
    assign deeper = $signed(rd_slot.depth) > $signed(fslot_reg.depth);
    assign id_match = ev_used && tid_reg != 32'd0 && rd_slot.id == tid_reg;
    assign zgt = $signed(rd_slot.depth) > $signed(maxz_reg);

    logic size_bad;
    assign size_bad = (w_reg == 15'd0) || (h_reg == 15'd0);

    // Write-back data: the located slot, the free slot on create, or each slot in the focus pass.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fidx_reg;
        wr_data = fslot_reg;
        if (state_reg == S_WRITE) begin
            unique case (func_reg)
                wtht_pkg::FN_CREATE: begin
                    wr_en   = free_reg && !size_bad;
                    wr_addr = free_idx_reg;
                    wr_data = '{id: next_id_reg, left: px_reg, top: py_reg,
                                width: w_reg, height: h_reg, depth: z_reg,
                                visible: 1'b1, focused: 1'b0};
                end
                wtht_pkg::FN_BOUNDS: begin
                    wr_en = fnd_reg && !size_bad;
                    wr_data.left = px_reg;
                    wr_data.top = py_reg;
                    wr_data.width = w_reg;
                    wr_data.height = h_reg;
                end
                wtht_pkg::FN_VISIBLE: begin
                    wr_en = fnd_reg;
                    wr_data.visible = vis_reg;
                end
                default: ;
            endcase
        end else if (state_reg == S_FWRITE) begin
            // Final focus pass: rewrite the focus mark of every used slot.
            wr_en   = ev_on_reg;
            wr_addr = ev_idx;
            wr_data = rd_slot;
            wr_data.focused = 1'b0;
            if (ev_idx == fidx_reg) begin
                wr_data.focused = 1'b1;
                wr_data.depth = maxz_reg + 32'd1;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer, scan accumulators and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            next_id_reg <= 32'd1;
            ev_on_reg   <= 1'b0;
            rd_cnt_reg  <= '0;
            ev_cnt_reg  <= '0;
            focus_clr_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg <= wtht_pkg::func_t'(s_func);
                        tid_reg <= s_target_id;
                        px_reg <= s_pos_x;
                        py_reg <= s_pos_y;
                        w_reg <= s_size_w;
                        h_reg <= s_size_h;
                        z_reg <= s_depth_z;
                        vis_reg <= s_visible_flag;
                        fnd_reg <= 1'b0;
                        free_reg <= 1'b0;
                        fslot_reg <= '0;
                        fidx_reg <= '0;
                        free_idx_reg <= '0;
                        rd_cnt_reg <= '0;
                        ev_on_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_FSCAN: begin
                    // Issue one read per cycle; evaluate the registered read data as it returns.
                    if (rd_cnt_reg != CW'(SLOTS)) begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    end
                    ev_on_reg  <= (rd_cnt_reg != CW'(SLOTS));
                    ev_cnt_reg <= rd_cnt_reg;
                    if (ev_on_reg) begin
                        if (state_reg == S_SCAN) begin
                            if (!ev_used && !free_reg) begin
                                free_reg <= 1'b1;
                                free_idx_reg <= ev_idx;
                            end
                            if (func_reg == wtht_pkg::FN_HIT) begin
                                if (contains && (!fnd_reg || deeper)) begin
                                    fnd_reg <= 1'b1;
                                    fidx_reg <= ev_idx;
                                    fslot_reg <= rd_slot;
                                end
                            end else if (id_match && !fnd_reg) begin
                                fnd_reg <= 1'b1;
                                fidx_reg <= ev_idx;
                                fslot_reg <= rd_slot;
                                maxz_reg <= rd_slot.depth;
                            end
                        end else if (ev_used && zgt) begin
                            maxz_reg <= rd_slot.depth;
                        end
                    end
                    if (!ev_on_reg && rd_cnt_reg == CW'(SLOTS)) begin
                        rd_cnt_reg <= '0;
                        if (state_reg == S_SCAN && func_reg == wtht_pkg::FN_FOCUS
                                && fnd_reg) begin
                            state_reg <= S_FSCAN;
                        end else if (state_reg == S_FSCAN) begin
                            focus_clr_reg <= valid_reg;
                            state_reg <= S_FWRITE;
                        end else begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_FWRITE: begin
                    // Re-read each slot and write back the focus mark of each used slot.
                    if (rd_cnt_reg != CW'(SLOTS)) begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    end
                    ev_on_reg  <= (rd_cnt_reg != CW'(SLOTS)) &&
                                  focus_clr_reg[rd_addr];
                    ev_cnt_reg <= rd_cnt_reg;
                    if (!ev_on_reg && rd_cnt_reg == CW'(SLOTS)) begin
                        o_status_reg <= wtht_pkg::ST_OK;
                        o_id_reg <= '0;
                        o_hit_reg <= 1'b0;
                        o_lx_reg <= '0;
                        o_ly_reg <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_WRITE: begin
                    o_id_reg <= '0;
                    o_hit_reg <= 1'b0;
                    o_lx_reg <= '0;
                    o_ly_reg <= '0;
                    o_status_reg <= wtht_pkg::ST_OK;
                    unique case (func_reg)
                        wtht_pkg::FN_CREATE: begin
                            if (size_bad) begin
                                o_status_reg <= wtht_pkg::ST_INVALID;
                            end else if (!free_reg) begin
                                o_status_reg <= wtht_pkg::ST_FULL;
                            end else begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                o_id_reg <= next_id_reg;
                                next_id_reg <= (next_id_reg == '1) ? 32'd1
                                               : next_id_reg + 32'd1;
                            end
                        end
                        wtht_pkg::FN_DESTROY: begin
                            if (fnd_reg) valid_reg[fidx_reg] <= 1'b0;
                            else o_status_reg <= wtht_pkg::ST_NOT_FOUND;
                        end
                        wtht_pkg::FN_BOUNDS: begin
                            if (!fnd_reg || size_bad)
                                o_status_reg <= wtht_pkg::ST_INVALID;
                        end
                        wtht_pkg::FN_FOCUS, wtht_pkg::FN_VISIBLE: begin
                            if (!fnd_reg) o_status_reg <= wtht_pkg::ST_NOT_FOUND;
                        end
                        wtht_pkg::FN_HIT: begin
                            if (fnd_reg) begin
                                o_id_reg <= fslot_reg.id;
                                o_hit_reg <= 1'b1;
                                o_lx_reg <= 15'(px_reg - fslot_reg.left);
                                o_ly_reg <= 15'(py_reg - fslot_reg.top);
                            end else begin
                                o_status_reg <= wtht_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: o_status_reg <= wtht_pkg::ST_INVALID;
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = (state_reg == S_DONE);
    assign m_status     = o_status_reg;
    assign m_surface_id = o_id_reg;
    assign m_hit        = o_hit_reg;
    assign m_local_x    = o_lx_reg;
    assign m_local_y    = o_ly_reg;
endmodule
